// File: hw/rtl/zero_equation_turbulent_viscosity_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the zero-equation turbulent viscosity unit.
// Each macro expands to a concurrent assertion clocked by clk and
// disabled while rst is high; it expands to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef ZERO_EQUATION_TURBULENT_VISCOSITY_UNIT_ASSERT_SVH
`define ZERO_EQUATION_TURBULENT_VISCOSITY_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define ZTV_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("ztv assertion failed");
`define ZTV_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("ztv assertion failed");
`else
`define ZTV_ASSERT_IMP(lbl, pre, post)
`define ZTV_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// File: hw/rtl/ztv_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ztv_pkg
// Types and register codes shared by the turbulent viscosity unit.
// ---------------------------------------------------------------------------
package ztv_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_BOUND_X_LOW  = 3'd0;
  localparam logic [2:0] REG_BOUND_X_HIGH = 3'd1;
  localparam logic [2:0] REG_BOUND_Y_LOW  = 3'd2;
  localparam logic [2:0] REG_BOUND_Y_HIGH = 3'd3;
  localparam logic [2:0] REG_BOUND_Z_LOW  = 3'd4;
  localparam logic [2:0] REG_BOUND_Z_HIGH = 3'd5;
  localparam logic [2:0] REG_STD_COEFF    = 3'd6;
  localparam logic [2:0] REG_WALL_COEFF   = 3'd7;

  localparam int FLUID_COUNT_W = 21;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [5:0]         solid_neighbours;
    logic               cell_is_fluid;
    logic               last_cell;
  } in_item_t;

  typedef struct packed {
    logic [31:0] turb_viscosity;
    logic [31:0] mean_diffusivity;
    logic        mean_valid;
    logic        no_fluid_cells;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic [1:0] axis;
    logic       sq_mul;
    logic       sq_acc;
    logic       sqrt_step;
    logic       mul_cd;
    logic       mul_cs;
    logic       nu_load;
    logic       mul_alpha;
    logic       div_mean_init;
    logic       div_step;
    logic       acc;
    logic       out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fluid;
    logic last;
    logic count_ok;
    logic count_zero;
    logic out_free;
  } dp_status_t;

endpackage

// File: hw/rtl/ztv_stream_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ztv_stream_if
// Valid/ready channel that carries one item per handshake.
// ---------------------------------------------------------------------------
interface ztv_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/ztv_ctrl.sv
`timescale 1ns / 1ps
`include "zero_equation_turbulent_viscosity_unit_assert.svh"
// ---------------------------------------------------------------------------
// ztv_ctrl
// Sequencer that steps the datapath through one cell: squares, square
// root, products, diffusivity product, accumulation, mean division.
// ---------------------------------------------------------------------------
module ztv_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ztv_pkg::dp_status_t status,
  output ztv_pkg::ctrl_cmd_t  cmd
);
  import ztv_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQ    = 4'd1;
  localparam logic [3:0] S_SQRT  = 4'd2;
  localparam logic [3:0] S_MUL1  = 4'd3;
  localparam logic [3:0] S_MUL2  = 4'd4;
  localparam logic [3:0] S_NU    = 4'd5;
  localparam logic [3:0] S_ACC   = 4'd7;
  localparam logic [3:0] S_MEANI = 4'd8;
  localparam logic [3:0] S_DIVM  = 4'd9;
  localparam logic [3:0] S_FIN   = 4'd10;

  // Last step index of each iterative phase.
  localparam logic [5:0] SqLast   = 6'd3;
  localparam logic [5:0] SqrtLast = 6'd31;
  localparam logic [5:0] DivMLast = 6'd55;

  logic [3:0] state, state_next;
  logic [5:0] cnt, cnt_next;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.axis   = cnt[1:0];
    in_ready   = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SQ;
          cnt_next   = '0;
        end
      end
      S_SQ: begin
        cmd.sq_mul = (cnt != SqLast);
        cmd.sq_acc = (cnt != 6'd0);
        cnt_next   = cnt + 6'd1;
        if (cnt == SqLast) begin
          state_next = S_SQRT;
          cnt_next   = '0;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next      = cnt + 6'd1;
        if (cnt == SqrtLast) begin
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul_cd = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul_cs = 1'b1;
        state_next = S_NU;
      end
      S_NU: begin
        cmd.nu_load = 1'b1;
        if (status.fluid && status.count_ok) begin
          cmd.mul_alpha = 1'b1;
          state_next    = S_ACC;
        end else begin
          state_next = S_MEANI;
        end
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_MEANI;
      end
      S_MEANI: begin
        if (status.last && !status.count_zero) begin
          cmd.div_mean_init = 1'b1;
          state_next        = S_DIVM;
          cnt_next          = '0;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DIVM: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 6'd1;
        if (cnt == DivMLast) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and step counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  `ZTV_ASSERT_NEXT(a_accept_starts_cell, in_valid && in_ready, state == S_SQ)
  `ZTV_ASSERT_IMP(a_out_load_when_free, cmd.out_load, status.out_free)
  `ZTV_ASSERT_IMP(a_mean_div_nonzero, cmd.div_mean_init, !status.count_zero)

endmodule

// File: hw/rtl/ztv_dp.sv
`timescale 1ns / 1ps
`include "zero_equation_turbulent_viscosity_unit_assert.svh"
// ---------------------------------------------------------------------------
// ztv_dp
// Datapath: configuration registers, wall distance, multipliers,
// bit-serial square root, restoring divider for the mean, sweep sums and
// the output register.
// ---------------------------------------------------------------------------
module ztv_dp #(
  parameter int MAX_CELLS = 1048576
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  ztv_pkg::in_item_t   in_data,
  input  ztv_pkg::ctrl_cmd_t  cmd,
  output ztv_pkg::dp_status_t status,
  output ztv_pkg::out_item_t  out_data,
  output logic                out_valid,
  input  logic                out_ready
);
  import ztv_pkg::*;

  localparam int CountMaxI = (1 << FLUID_COUNT_W) - 1;
  localparam logic [FLUID_COUNT_W-1:0] CountLimit =
    FLUID_COUNT_W'((MAX_CELLS < CountMaxI) ? MAX_CELLS : CountMaxI);

  // Reciprocal of 9 scaled by 2^33; exact floor division for 32-bit inputs.
  localparam logic [31:0] Recip9 = 32'h38E3_8E39;

  // Configuration registers.
  logic signed [31:0] bxl, bxh, byl, byh, bzl, bzh;
  logic [15:0]        std_coeff, wall_coeff;

  // Latched cell.
  logic signed [31:0] px, py, pz, vx, vy, vz;
  logic               solid_any, fluid, last;

  // Working registers.
  logic signed [32:0] dmin;
  logic [63:0]        prod;
  logic [63:0]        sumsq;
  logic [63:0]        res;
  logic [63:0]        sbit;
  logic [31:0]        nu;
  logic [55:0]        dvd;
  logic [20:0]        rem;
  logic [20:0]        den;
  logic [55:0]        sum;
  logic [FLUID_COUNT_W-1:0] count;

  logic signed [31:0] p_sel, lo_sel, hi_sel, v_sel;
  logic signed [32:0] dlo, dhi, dax;
  logic [31:0]        vabs, wall_dist, cl, nu_sat;
  logic [15:0]        coeff;
  logic [63:0]        trial;
  logic [32:0]        alpha;
  logic [21:0]        rshift;
  logic               qbit;
  logic [56:0]        sum_add;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      bxl        <= 32'sd0;
      bxh        <= 32'sd65536;
      byl        <= 32'sd0;
      byh        <= 32'sd65536;
      bzl        <= 32'sd0;
      bzh        <= 32'sd65536;
      std_coeff  <= 16'd2539;
      wall_coeff <= 16'd1212;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BOUND_X_LOW:  bxl <= cfg_data;
        REG_BOUND_X_HIGH: bxh <= cfg_data;
        REG_BOUND_Y_LOW:  byl <= cfg_data;
        REG_BOUND_Y_HIGH: byh <= cfg_data;
        REG_BOUND_Z_LOW:  bzl <= cfg_data;
        REG_BOUND_Z_HIGH: bzh <= cfg_data;
        REG_STD_COEFF:    std_coeff <= cfg_data[15:0];
        REG_WALL_COEFF:   wall_coeff <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Axis selection for the distance and square steps.
  always_comb begin
    case (cmd.axis)
      2'd0: begin
        p_sel = px; lo_sel = bxl; hi_sel = bxh; v_sel = vx;
      end
      2'd1: begin
        p_sel = py; lo_sel = byl; hi_sel = byh; v_sel = vy;
      end
      default: begin
        p_sel = pz; lo_sel = bzl; hi_sel = bzh; v_sel = vz;
      end
    endcase
  end

  // Arithmetic feeding the working registers.
  always_comb begin
    dlo       = {p_sel[31], p_sel} - {lo_sel[31], lo_sel};
    dhi       = {hi_sel[31], hi_sel} - {p_sel[31], p_sel};
    dax       = (dlo < dhi) ? dlo : dhi;
    vabs      = v_sel[31] ? (~v_sel + 32'd1) : v_sel;
    wall_dist = dmin[32] ? 32'd0 : dmin[31:0];
    coeff     = solid_any ? wall_coeff : std_coeff;
    cl        = prod[47:16];
    nu_sat    = (prod[63:48] != 16'd0) ? 32'hFFFF_FFFF : prod[47:16];
    trial     = res + sbit;
    // Ten ninths of the viscosity is the viscosity plus its ninth.
    alpha     = {1'b0, nu} + {2'b00, prod[63:33]};
    rshift    = {rem, dvd[55]};
    qbit      = (rshift >= {1'b0, den});
    sum_add   = {1'b0, sum} + {24'd0, alpha};
  end

  // Cell pipeline of the iterative units.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px        <= in_data.pos_x;
      py        <= in_data.pos_y;
      pz        <= in_data.pos_z;
      vx        <= in_data.vel_x;
      vy        <= in_data.vel_y;
      vz        <= in_data.vel_z;
      solid_any <= (in_data.solid_neighbours != 6'd0);
      fluid     <= in_data.cell_is_fluid;
      last      <= in_data.last_cell;
      dmin      <= 33'sh0_FFFF_FFFF;
      sumsq     <= '0;
      res       <= '0;
      sbit      <= 64'h4000_0000_0000_0000;
    end
    // Squares of the velocity components and the wall distance.
    if (cmd.sq_mul) begin
      prod <= 64'(vabs) * 64'(vabs);
      if (dax < dmin) begin
        dmin <= dax;
      end
    end
    if (cmd.sq_acc) begin
      sumsq <= sumsq + prod;
    end
    // One result bit of the square root per step.
    if (cmd.sqrt_step) begin
      if (sumsq >= trial) begin
        sumsq <= sumsq - trial;
        res   <= (res >> 1) + sbit;
      end else begin
        res <= res >> 1;
      end
      sbit <= sbit >> 2;
    end
    // Coefficient times distance, then times speed.
    if (cmd.mul_cd) begin
      prod <= 64'(coeff) * 64'(wall_dist);
    end
    if (cmd.mul_cs) begin
      prod <= 64'(cl) * 64'(res[31:0]);
    end
    if (cmd.nu_load) begin
      nu <= nu_sat;
    end
    // Viscosity times the reciprocal of 9 for the diffusivity.
    if (cmd.mul_alpha) begin
      prod <= 64'(nu_sat) * 64'(Recip9);
    end
    // Restoring divider for the mean, one quotient bit per step.
    if (cmd.div_mean_init) begin
      dvd <= sum;
      den <= count;
      rem <= '0;
    end
    if (cmd.div_step) begin
      rem <= qbit ? 21'(rshift - {1'b0, den}) : rshift[20:0];
      dvd <= {dvd[54:0], qbit};
    end
  end

  // Sweep sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      count <= '0;
    end else if (cmd.acc) begin
      sum   <= sum_add[56] ? {56{1'b1}} : sum_add[55:0];
      count <= count + 1'b1;
    end else if (cmd.out_load && last) begin
      sum   <= '0;
      count <= '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.turb_viscosity   <= nu;
      out_data.mean_diffusivity <= 32'd0;
      out_data.mean_valid       <= 1'b0;
      out_data.no_fluid_cells   <= 1'b0;
      if (last) begin
        if (count == '0) begin
          out_data.no_fluid_cells <= 1'b1;
        end else begin
          out_data.mean_valid       <= 1'b1;
          out_data.mean_diffusivity <= (dvd[55:32] != 24'd0) ? 32'hFFFF_FFFF
                                                              : dvd[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Status back to the controller.
  always_comb begin
    status.fluid      = fluid;
    status.last       = last;
    status.count_ok   = (count < CountLimit);
    status.count_zero = (count == '0);
    status.out_free   = !out_valid || out_ready;
  end

  `ZTV_ASSERT_IMP(a_count_bounded, 1'b1, count <= CountLimit)
  `ZTV_ASSERT_IMP(a_mean_flags_excl, out_valid, !(out_data.mean_valid && out_data.no_fluid_cells))
  `ZTV_ASSERT_NEXT(a_load_shows_item, cmd.out_load, out_valid)

endmodule

// File: hw/rtl/zero_equation_turbulent_viscosity_unit.sv
`timescale 1ns / 1ps
// Each cell passes the square, square root, product and viscosity steps, then the
// accumulate step for a fluid cell that joins the mean and the mean divide on a
// last cell whose sweep had fluid cells; a stalled output adds its wait.
// The unit takes one cell at a time and accepts the next once its result is
// loaded; the 32-step square root sets the rate, a last cell adds the 56-step divide.
// Reset (synchronous, rst high) restores register defaults and clears the sums.
// ---------------------------------------------------------------------------
// zero_equation_turbulent_viscosity_unit
// Mixing-length turbulent viscosity per cell with a sweep mean diffusivity.
// ---------------------------------------------------------------------------
module zero_equation_turbulent_viscosity_unit #(
  parameter int MAX_CELLS = 1048576
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  ztv_stream_if.sink  in_ch,
  ztv_stream_if.source out_ch
);
  import ztv_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  ztv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  ztv_dp #(
    .MAX_CELLS (MAX_CELLS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_ch.data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready)
  );

endmodule

// File: tb/sv/tb_ztv_checks.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_ztv_checks
// Timing constants shared by the tests of the turbulent viscosity unit.
// ---------------------------------------------------------------------------
package tb_ztv_pkg;

  // Cycles the receiver holds off in the backpressure test.
  localparam int LONG_HOLD_CYCLES = 600;
  // Quiet cycles after the last result before registers change.
  localparam int DRAIN_CYCLES = 200;
endpackage

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Cell-stream test of the turbulent viscosity unit: directed corner cells,
// random sweeps under several idle patterns and bound settings, each result
// checked against an in-bench prediction of viscosity and sweep mean.
// ---------------------------------------------------------------------------
module tb_top;
  import ztv_pkg::*;
  import tb_ztv_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  ztv_stream_if #(.item_t(in_item_t))  cell_ch ();
  ztv_stream_if #(.item_t(out_item_t)) visc_ch ();

  zero_equation_turbulent_viscosity_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (cell_ch.sink),
    .out_ch    (visc_ch.source)
  );

  // Shadow copy of the unit's registers and sweep state.
  logic signed [31:0] bnd_lo [3];
  logic signed [31:0] bnd_hi [3];
  logic [15:0]        coeff_std;
  logic [15:0]        coeff_wall;
  logic [55:0]        sweep_sum;
  logic [20:0]        sweep_count;

  out_item_t   expected_q [$];
  int          error_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_off;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog.
  initial begin
    #50ms;
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Exact integer square root of a 64-bit value.
  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] abs_sq(input logic signed [31:0] v);
    logic [63:0] a;
    a = v[31] ? 64'(-$signed({v[31], v})) : 64'(v);
    return a * a;
  endfunction

  // Predict one cell's result and advance the sweep state.
  function automatic out_item_t predict_cell(input in_item_t c);
    out_item_t          r;
    logic signed [63:0] p [3];
    logic signed [63:0] d;
    logic signed [63:0] t;
    logic [63:0]        wall_dist, coeff, speed, cl, nu, alpha, mean;
    logic [64:0]        sum_ext;
    logic [127:0]       prod;
    p[0] = c.pos_x;
    p[1] = c.pos_y;
    p[2] = c.pos_z;
    d = 64'sh7FFF_FFFF_FFFF_FFFF;
    for (int a = 0; a < 3; a++) begin
      t = p[a] - 64'(bnd_lo[a]);
      if (t < d) d = t;
      t = 64'(bnd_hi[a]) - p[a];
      if (t < d) d = t;
    end
    wall_dist = d < 0 ? 64'd0 : 64'(d);
    coeff = c.solid_neighbours != 0 ? 64'(coeff_wall) : 64'(coeff_std);
    speed = int_sqrt(abs_sq(c.vel_x) + abs_sq(c.vel_y) + abs_sq(c.vel_z));
    cl = (coeff * wall_dist) >> 16;
    prod = 128'(cl) * 128'(speed);
    if (prod[127:64] != 0) nu = 64'hFFFF_FFFF;
    else begin
      nu = prod[63:0] >> 16;
      if (nu > 64'hFFFF_FFFF) nu = 64'hFFFF_FFFF;
    end
    if (c.cell_is_fluid && sweep_count < 21'd1048576) begin
      alpha = (nu * 10) / 9;
      sum_ext = 65'(sweep_sum) + 65'(alpha);
      sweep_sum = sum_ext > 65'({56{1'b1}}) ? {56{1'b1}} : sum_ext[55:0];
      sweep_count++;
    end
    r = '0;
    r.turb_viscosity = nu[31:0];
    if (c.last_cell) begin
      if (sweep_count == 0) r.no_fluid_cells = 1'b1;
      else begin
        mean = 64'(sweep_sum) / 64'(sweep_count);
        r.mean_diffusivity = mean > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : mean[31:0];
        r.mean_valid = 1'b1;
      end
      sweep_sum = '0;
      sweep_count = '0;
    end
    return r;
  endfunction

  // Receiver: random stalls, long hold-off on request.
  initial begin
    visc_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      visc_ch.ready <= !rst && !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && visc_ch.valid && visc_ch.ready) begin
      if (expected_q.size() == 0) report("unexpected item", visc_ch.data.turb_viscosity, 32'd0);
      else begin
        e = expected_q.pop_front();
        if (visc_ch.data.turb_viscosity !== e.turb_viscosity)
          report("turb_viscosity", visc_ch.data.turb_viscosity, e.turb_viscosity);
        if (visc_ch.data.mean_diffusivity !== e.mean_diffusivity)
          report("mean_diffusivity", visc_ch.data.mean_diffusivity, e.mean_diffusivity);
        if (visc_ch.data.mean_valid !== e.mean_valid)
          report("mean_valid", visc_ch.data.mean_valid, e.mean_valid);
        if (visc_ch.data.no_fluid_cells !== e.no_fluid_cells)
          report("no_fluid_cells", visc_ch.data.no_fluid_cells, e.no_fluid_cells);
      end
    end
  end

  // Send one cell: optional idle, then hold valid until accepted.
  // Valid stays high after the accept until the next cell or the drain.
  task automatic send_cell(input in_item_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      cell_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cell_ch.valid <= 1'b1;
    cell_ch.data  <= c;
    @(posedge clk);
    while (!cell_ch.ready) @(posedge clk);
    expected_q.push_back(predict_cell(c));
  endtask

  task automatic drain_results();
    cell_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_BOUND_X_LOW:  bnd_lo[0] = val;
      REG_BOUND_X_HIGH: bnd_hi[0] = val;
      REG_BOUND_Y_LOW:  bnd_lo[1] = val;
      REG_BOUND_Y_HIGH: bnd_hi[1] = val;
      REG_BOUND_Z_LOW:  bnd_lo[2] = val;
      REG_BOUND_Z_HIGH: bnd_hi[2] = val;
      REG_STD_COEFF:    coeff_std = val[15:0];
      REG_WALL_COEFF:   coeff_wall = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_box(input logic signed [31:0] lo, input logic signed [31:0] hi);
    write_reg(REG_BOUND_X_LOW, lo);
    write_reg(REG_BOUND_X_HIGH, hi);
    write_reg(REG_BOUND_Y_LOW, lo);
    write_reg(REG_BOUND_Y_HIGH, hi);
    write_reg(REG_BOUND_Z_LOW, lo);
    write_reg(REG_BOUND_Z_HIGH, hi);
  endtask

  // Random cell; mostly positions inside the box, sometimes anything.
  function automatic in_item_t random_cell(input int last_pct);
    in_item_t c;
    logic [31:0] span;
    span = bnd_hi[0] - bnd_lo[0];
    if ($urandom_range(9) < 8 && $signed(span) > 0) begin
      c.pos_x = bnd_lo[0] + $urandom_range(span);
      c.pos_y = bnd_lo[1] + $urandom_range(bnd_hi[1] - bnd_lo[1]);
      c.pos_z = bnd_lo[2] + $urandom_range(bnd_hi[2] - bnd_lo[2]);
    end else begin
      c.pos_x = $urandom;
      c.pos_y = $urandom;
      c.pos_z = $urandom;
    end
    if ($urandom_range(3) == 0) begin
      c.vel_x = $urandom;
      c.vel_y = $urandom;
      c.vel_z = $urandom;
    end else begin
      c.vel_x = $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
      c.vel_y = $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
      c.vel_z = $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
    end
    c.solid_neighbours = $urandom_range(1) ? 6'($urandom) : 6'd0;
    c.cell_is_fluid = $urandom_range(9) < 7;
    c.last_cell = $urandom_range(99) < last_pct;
    return c;
  endfunction

  function automatic in_item_t make_cell(input logic signed [31:0] p,
                                         input logic signed [31:0] v,
                                         input logic [5:0] solid,
                                         input logic fluid, input logic last);
    in_item_t c;
    c.pos_x = p;
    c.pos_y = p;
    c.pos_z = p;
    c.vel_x = v;
    c.vel_y = v;
    c.vel_z = v;
    c.solid_neighbours = solid;
    c.cell_is_fluid = fluid;
    c.last_cell = last;
    return c;
  endfunction

  // Corner cells under reset settings, then under other bounds and coefficients.
  task automatic test_directed();
    send_cell(make_cell(32'sh8000, 32'sh1_0000, 6'd0, 1'b1, 1'b0));
    send_cell(make_cell(32'sh8000, 32'sh1_0000, 6'h3F, 1'b1, 1'b0));
    send_cell(make_cell(32'sh8000, 32'sh8000_0000, 6'd1, 1'b1, 1'b0));
    send_cell(make_cell(32'sh8000, 32'sh7FFF_FFFF, 6'h20, 1'b0, 1'b1));
    // Last cell with no fluid cells in its sweep.
    send_cell(make_cell(32'sh4000, 32'sh1_0000, 6'd0, 1'b0, 1'b1));
    // Outside the domain: distance clamps to zero.
    send_cell(make_cell(32'sh8000_0000, 32'sh1_0000, 6'd0, 1'b1, 1'b0));
    send_cell(make_cell(32'sh7FFF_FFFF, 32'sh1_0000, 6'd0, 1'b1, 1'b0));
    send_cell(make_cell(32'sh8000, 32'sh0, 6'd0, 1'b1, 1'b1));
    send_cell(make_cell(32'shFFFF_FFFF, 32'shFFFF_FFFF, 6'h15, 1'b1, 1'b1));
    drain_results();
    // Widest box and saturating coefficients.
    set_box(32'sh8000_0000, 32'sh7FFF_FFFF);
    write_reg(REG_STD_COEFF, 32'hFFFF);
    write_reg(REG_WALL_COEFF, 32'hFFFF);
    send_cell(make_cell(32'sh0, 32'sh7FFF_FFFF, 6'd0, 1'b1, 1'b0));
    send_cell(make_cell(32'sh0, 32'sh8000_0000, 6'h3F, 1'b1, 1'b1));
    send_cell(make_cell(32'sh1234_5678, 32'sh0000_0001, 6'd0, 1'b1, 1'b1));
    drain_results();
    write_reg(REG_BOUND_X_LOW, 32'sh1_0000);
    write_reg(REG_BOUND_X_HIGH, 32'sh0);
    write_reg(REG_STD_COEFF, 32'h0);
    write_reg(REG_WALL_COEFF, 32'h0);
    send_cell(make_cell(32'sh8000, 32'sh1_0000, 6'd0, 1'b1, 1'b1));
    send_cell(make_cell(32'sh8000, 32'sh1_0000, 6'd2, 1'b1, 1'b1));
    drain_results();
  endtask

  // Random sweeps under one idle pattern and one box.
  task automatic test_random(input int n, input int idle, input int stall,
                             input logic signed [31:0] lo, input logic signed [31:0] hi,
                             input logic [15:0] cs, input logic [15:0] cw);
    set_box(lo, hi);
    write_reg(REG_STD_COEFF, 32'(cs));
    write_reg(REG_WALL_COEFF, 32'(cw));
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) send_cell(random_cell(8));
    drain_results();
  endtask

  // Receiver holds off while cells keep coming, then sender waits for all.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 10; i++) send_cell(random_cell(20));
    join
    drain_results();
    for (int i = 0; i < 5; i++) send_cell(random_cell(20));
    drain_results();
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cell_ch.valid = 1'b0;
    cell_ch.data = '0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    error_count = 0;
    bnd_lo = '{3{32'sh0}};
    bnd_hi = '{3{32'sh1_0000}};
    coeff_std = 16'd2539;
    coeff_wall = 16'd1212;
    sweep_sum = '0;
    sweep_count = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(250, 0, 0, 32'sh0, 32'sh1_0000, 16'd2539, 16'd1212);
    test_random(220, 79, 0, 32'shFFFF_0000, 32'sh0004_0000, 16'hFFFF, 16'd1);
    test_random(220, 0, 79, 32'sh0, 32'sh0100_0000, 16'd4000, 16'd900);
    test_random(220, 21, 21, 32'sh8000_0000, 32'sh7FFF_FFFF, 16'd77, 16'hFFFF);
    test_random(220, 0, 0, 32'sh0, 32'sh1_0000, 16'd2539, 16'd1212);
    test_backpressure();
    if (error_count == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end
endmodule
